@@ hw/rtl/des_rf_pkg.sv @@
// ----------------------------------------------------------------------------
// DES round function package
// Shared constants, S-box and P tables, and the E expansion for the f function.
// ----------------------------------------------------------------------------
package des_rf_pkg;

    localparam int SBOX_COUNT = 8;
    localparam int HALF_W     = 32;
    localparam int KEY_W      = 48;
    localparam int CHUNK_W    = 6;
    localparam int NIB_W      = 4;

    typedef logic [CHUNK_W-1:0]   t_chunk;
    typedef logic [NIB_W-1:0]     t_nibble;
    typedef logic [2:0]           t_box_idx;
    typedef logic [4:0]           t_bit_pos;
    typedef logic [HALF_W-1:0]    t_half;
    typedef logic [KEY_W-1:0]     t_key;

    localparam t_nibble SBOX_TAB [SBOX_COUNT][4][16] = '{
        '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
            4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
          '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
            4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
          '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
            4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
          '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
            4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
        '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
            4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
          '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
            4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
          '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
            4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
          '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
            4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
        '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
            4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
          '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
            4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
          '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
            4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
          '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
            4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
        '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
            4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
          '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
            4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
          '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
            4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
          '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
            4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
        '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
            4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
          '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
            4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
          '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
            4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
          '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
            4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
        '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
            4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
          '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
            4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
          '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
            4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
          '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
            4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
        '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
            4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
          '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
            4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
          '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
            4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
          '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
            4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
        '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
            4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
          '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
            4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
          '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
            4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
          '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
            4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}}
    };

    // Target bit of each S-box output bit, MSB of the nibble first.
    localparam t_bit_pos P_ROUTE [SBOX_COUNT][NIB_W] = '{
        '{5'd23, 5'd15, 5'd9,  5'd1},  '{5'd19, 5'd4,  5'd30, 5'd14},
        '{5'd8,  5'd16, 5'd2,  5'd26}, '{5'd6,  5'd12, 5'd22, 5'd31},
        '{5'd24, 5'd18, 5'd7,  5'd29}, '{5'd28, 5'd3,  5'd21, 5'd13},
        '{5'd0,  5'd20, 5'd10, 5'd25}, '{5'd27, 5'd5,  5'd17, 5'd11}
    };

    // E expansion. The half is wrapped into a 34-bit ring and each 6-bit
    // chunk overlaps its neighbors by one bit on each side.
    function automatic t_key expand_half(input t_half half);
        logic [HALF_W+1:0] ring;
        t_key              e;
        ring = {half[0], half, half[HALF_W-1]};
        for (int i = 0; i < SBOX_COUNT; i++) begin
            e[KEY_W-1-CHUNK_W*i -: CHUNK_W] = ring[HALF_W+1-NIB_W*i -: CHUNK_W];
        end
        return e;
    endfunction

endpackage

@@ hw/rtl/des_rf_sbox.sv @@
// ----------------------------------------------------------------------------
// DES round function S-box lane
// Mixes one expanded chunk with its subkey chunk and looks up one S-box.
// ----------------------------------------------------------------------------
module des_rf_sbox (
    input  des_rf_pkg::t_box_idx i_box,
    input  des_rf_pkg::t_chunk   i_chunk,
    input  des_rf_pkg::t_chunk   i_key,
    output des_rf_pkg::t_nibble  o_sbox
);
    import des_rf_pkg::*;

    t_chunk   mixed;
    logic [1:0] row;
    logic [3:0] col;

    assign mixed  = i_chunk ^ i_key;
    // Row comes from the outer bits, column from the middle four.
    assign row    = {mixed[5], mixed[0]};
    assign col    = mixed[4:1];
    assign o_sbox = SBOX_TAB[i_box][row][col];

endmodule

@@ hw/rtl/des_rf_merge.sv @@
// ----------------------------------------------------------------------------
// DES round function merge stage
// Routes the eight S-box nibbles through the P permutation into one word.
// ----------------------------------------------------------------------------
module des_rf_merge (
    input  des_rf_pkg::t_nibble i_sbox [des_rf_pkg::SBOX_COUNT],
    output des_rf_pkg::t_half   o_word
);
    import des_rf_pkg::*;

    always_comb begin
        o_word = '0;
        for (int i = 0; i < SBOX_COUNT; i++) begin
            for (int j = 0; j < NIB_W; j++) begin
                o_word[P_ROUTE[i][j]] = i_sbox[i][NIB_W-1-j];
            end
        end
    end

endmodule

@@ hw/rtl/des_round_function.sv @@
// An accepted input is registered in the result register, or in the skid register while a result waits.
// Throughput: one transaction per cycle while the skid register is empty; eight S-box lanes evaluate in parallel.
// A two-entry output stage (result register plus skid register) keeps input
// accepted while one result waits to be taken.
// Reset (synchronous, active low) empties both output entries.
// ----------------------------------------------------------------------------
// DES round function f
// Expansion, subkey mix, eight parallel S-box lanes, P merge, output buffer.
// ----------------------------------------------------------------------------
module des_round_function (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  des_rf_pkg::t_half  i_right_half,
    input  des_rf_pkg::t_key   i_round_subkey,
    output logic               o_valid,
    input  logic               i_ready,
    output des_rf_pkg::t_half  o_f_result
);
    import des_rf_pkg::*;

    t_key    expanded;
    t_nibble sbox_out [SBOX_COUNT];
    t_half   f_word;

    logic    r_valid;
    t_half   r_data;
    logic    r_skid_valid;
    t_half   r_skid_data;
    logic    in_fire;
    logic    out_fire;

    assign expanded = expand_half(i_right_half);

    for (genvar g = 0; g < SBOX_COUNT; g++) begin : g_lane
        des_rf_sbox u_sbox (
            .i_box   (t_box_idx'(g)),
            .i_chunk (expanded[KEY_W-1-CHUNK_W*g -: CHUNK_W]),
            .i_key   (i_round_subkey[KEY_W-1-CHUNK_W*g -: CHUNK_W]),
            .o_sbox  (sbox_out[g])
        );
    end

    des_rf_merge u_merge (
        .i_sbox (sbox_out),
        .o_word (f_word)
    );

    assign o_ready    = !r_skid_valid;
    assign in_fire    = i_valid && o_ready;
    assign out_fire   = r_valid && i_ready;
    assign o_valid    = r_valid;
    assign o_f_result = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_valid || out_fire) begin
            // Output entry is free this cycle: drain the skid first.
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_data       <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid      <= in_fire;
                r_data       <= f_word;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= f_word;
        end
    end

endmodule

@@ hw/rtl/des_rf_checker.sv @@
// ----------------------------------------------------------------------------
// DES round function checker
// Port-level properties of the round function, bound to the top level.
// ----------------------------------------------------------------------------
module des_rf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input des_rf_pkg::t_half o_f_result
);
    import des_rf_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_f_result))
        else $error("result payload changed while stalled");

    // Input back-pressure only happens when a result is already waiting.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    // Every accepted input transaction is followed on the next cycle by o_valid high.
    a_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted transaction produced no result");

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output not empty after reset");

endmodule

bind des_round_function des_rf_checker u_des_rf_checker (.*);
